// ===== sv/dgcd_pkg.sv =====
// Shared types, widths and the sequencer program for the graph cycle detector.
package dgcd_pkg;

  localparam int NODES  = 32;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int OP_W   = 2;

  typedef logic [NODES-1:0]  row_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RUN   = 2'd2
  } op_t;

  // One stack frame: node and next neighbor to examine.
  typedef struct packed {
    node_t node;
    cnt_t  next;
  } frame_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_ROOT, S_ROOTV, S_TOP, S_SCAN,
    S_EDGE, S_PUSH, S_NROOT, S_RES0, S_RES1, S_OUT
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_START, C_ROOT_END, C_ROOT_VIS,
    C_SP_ZERO, C_NO_EDGE, C_ON_PATH, C_OUT_FULL
  } cond_t;

  typedef enum logic [3:0] {
    A_NONE, A_IDLE, A_INIT, A_ROOT, A_SCAN,
    A_PUSH, A_ROOT_INC, A_RES0, A_RES1, A_EMIT
  } act_t;

  typedef struct packed {
    cond_t cond;
    act_t  act;
    step_t on_true;
    step_t on_false;
  } uword_t;

  // Control store: one word per step.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_IDLE:  w = '{C_START,    A_IDLE,     S_INIT,  S_IDLE};
      S_INIT:  w = '{C_ALWAYS,   A_INIT,     S_ROOT,  S_ROOT};
      S_ROOT:  w = '{C_ROOT_END, A_NONE,     S_RES0,  S_ROOTV};
      S_ROOTV: w = '{C_ROOT_VIS, A_ROOT,     S_ROOT,  S_TOP};
      S_TOP:   w = '{C_SP_ZERO,  A_NONE,     S_NROOT, S_SCAN};
      S_SCAN:  w = '{C_NO_EDGE,  A_SCAN,     S_TOP,   S_EDGE};
      S_EDGE:  w = '{C_ON_PATH,  A_NONE,     S_RES1,  S_PUSH};
      S_PUSH:  w = '{C_ALWAYS,   A_PUSH,     S_TOP,   S_TOP};
      S_NROOT: w = '{C_ALWAYS,   A_ROOT_INC, S_ROOT,  S_ROOT};
      S_RES0:  w = '{C_ALWAYS,   A_RES0,     S_OUT,   S_OUT};
      S_RES1:  w = '{C_ALWAYS,   A_RES1,     S_OUT,   S_OUT};
      S_OUT:   w = '{C_OUT_FULL, A_EMIT,     S_OUT,   S_IDLE};
      default: w = '{C_ALWAYS,   A_NONE,     S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/dgcd_if.sv =====
// Handshake channels of the graph cycle detector: command, result and config.
interface dgcd_in_if import dgcd_pkg::*;;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  node_t           src_node;
  node_t           dst_node;
  modport source (output valid, opcode, src_node, dst_node, input ready);
  modport sink   (input valid, opcode, src_node, dst_node, output ready);
endinterface

interface dgcd_out_if;
  logic valid;
  logic ready;
  logic cyclic;
  modport source (output valid, cyclic, input ready);
  modport sink   (input valid, cyclic, output ready);
endinterface

interface dgcd_cfg_if import dgcd_pkg::*;;
  logic valid;
  logic ready;
  cnt_t node_count;
  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

// ===== sv/directed_graph_cycle_detect.sv =====
// Directed graph cycle detector. An add-edge or clear-graph word is taken while the
// block is idle. A run word starts a depth-first walk driven by a microcoded
// sequencer, one control step per cycle: it clears the marks, tries each root in turn
// and opens a walk from each unvisited one, examines each edge of the node on top of
// the stack, retires a node from the stack once its row is used up, and closes with
// the last root check, the result and the post; a cycle ends the walk early.
// The next neighbor of a node is picked combinationally from its adjacency row; the
// step sequencing sets the rate. No words are taken during a run; the result sits in
// an output register and edge loads may go on while it waits to be taken.
module directed_graph_cycle_detect import dgcd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  dgcd_in_if.sink       in_ch,
  dgcd_out_if.source    out_ch,
  dgcd_cfg_if.sink      cfg_ch
);

  step_t  upc_r, upc_nxt;
  row_t   adj_r   [NODES];
  row_t   adj_nxt [NODES];
  frame_t stk_r   [NODES];
  frame_t stk_nxt [NODES];
  row_t   vis_r, vis_nxt;
  row_t   onp_r, onp_nxt;
  cnt_t   sp_r, sp_nxt;
  cnt_t   root_r, root_nxt;
  node_t  w_r, w_nxt;
  cnt_t   ncnt_r, ncnt_nxt;
  logic   res_r, res_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_cyclic_r, out_cyclic_nxt;

  uword_t uw;
  logic   cond;
  cnt_t   n_act;
  node_t  top_idx;
  frame_t top;
  row_t   cand;
  logic   found;
  node_t  pick;
  logic   in_hs;

  assign uw      = ucode(upc_r);
  assign n_act   = (ncnt_r > cnt_t'(NODES)) ? cnt_t'(NODES) : ncnt_r;
  assign top_idx = node_t'(sp_r - cnt_t'(1));
  assign top     = stk_r[top_idx];
  // neighbors of the top node from its next index up to the active count
  assign cand    = adj_r[top.node] & ({NODES{1'b1}} << top.next)
                   & ~({NODES{1'b1}} << n_act);
  assign found   = |cand;

  always_comb begin
    pick = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (cand[i]) pick = node_t'(i);
    end
  end

  assign in_ch.ready   = (uw.act == A_IDLE);
  assign in_hs         = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.cyclic = out_cyclic_r;

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond = 1'b1;
      C_START:    cond = in_hs && (op_t'(in_ch.opcode) == OP_RUN);
      C_ROOT_END: cond = (root_r >= n_act);
      C_ROOT_VIS: cond = vis_r[root_r[NODE_W-1:0]];
      C_SP_ZERO:  cond = (sp_r == '0);
      C_NO_EDGE:  cond = !found;
      C_ON_PATH:  cond = onp_r[w_r];
      C_OUT_FULL: cond = out_valid_r && !out_ch.ready;
      default:    cond = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt        = cond ? uw.on_true : uw.on_false;
    adj_nxt        = adj_r;
    stk_nxt        = stk_r;
    vis_nxt        = vis_r;
    onp_nxt        = onp_r;
    sp_nxt         = sp_r;
    root_nxt       = root_r;
    w_nxt          = w_r;
    res_nxt        = res_r;
    ncnt_nxt       = ncnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_cyclic_nxt = out_cyclic_r;

    if (cfg_ch.valid) ncnt_nxt = cfg_ch.node_count;

    case (uw.act)
      A_IDLE: begin
        if (in_hs) begin
          case (op_t'(in_ch.opcode))
            OP_ADD:   adj_nxt[in_ch.src_node][in_ch.dst_node] = 1'b1;
            OP_CLEAR: adj_nxt = '{default: '0};
            default:  ;
          endcase
        end
      end
      A_INIT: begin
        vis_nxt  = '0;
        onp_nxt  = '0;
        sp_nxt   = '0;
        root_nxt = '0;
      end
      A_ROOT: begin
        if (cond) begin
          root_nxt = root_r + cnt_t'(1);
        end else begin
          vis_nxt[root_r[NODE_W-1:0]] = 1'b1;
          onp_nxt[root_r[NODE_W-1:0]] = 1'b1;
          stk_nxt[0] = '{node: root_r[NODE_W-1:0], next: '0};
          sp_nxt     = cnt_t'(1);
        end
      end
      A_SCAN: begin
        if (!found) begin
          onp_nxt[top.node] = 1'b0;
          sp_nxt            = sp_r - cnt_t'(1);
        end else begin
          stk_nxt[top_idx].next = cnt_t'(pick) + cnt_t'(1);
          w_nxt                 = pick;
        end
      end
      A_PUSH: begin
        if (!vis_r[w_r] && (sp_r < cnt_t'(NODES))) begin
          vis_nxt[w_r] = 1'b1;
          onp_nxt[w_r] = 1'b1;
          stk_nxt[sp_r[NODE_W-1:0]] = '{node: w_r, next: '0};
          sp_nxt = sp_r + cnt_t'(1);
        end
      end
      A_ROOT_INC: root_nxt = root_r + cnt_t'(1);
      A_RES0:     res_nxt  = 1'b0;
      A_RES1: begin
        res_nxt = 1'b1;
        sp_nxt  = '0;
      end
      A_EMIT: begin
        if (!cond) begin
          out_valid_nxt  = 1'b1;
          out_cyclic_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      adj_r       <= '{default: '0};
      vis_r       <= '0;
      onp_r       <= '0;
      sp_r        <= '0;
      root_r      <= '0;
      ncnt_r      <= cnt_t'(NODES);
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      adj_r       <= adj_nxt;
      vis_r       <= vis_nxt;
      onp_r       <= onp_nxt;
      sp_r        <= sp_nxt;
      root_r      <= root_nxt;
      ncnt_r      <= ncnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    stk_r        <= stk_nxt;
    w_r          <= w_nxt;
    res_r        <= res_nxt;
    out_cyclic_r <= out_cyclic_nxt;
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= cnt_t'(NODES))
    else $error("stack depth past node count");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_IDLE) |-> (sp_r == '0))
    else $error("stack not empty while idle");

  a_path_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (onp_r & ~vis_r) == '0)
    else $error("node on path but not visited");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_hs && (op_t'(in_ch.opcode) == OP_RUN)) |=> (upc_r == S_INIT))
    else $error("run word did not start the walk");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the directed graph cycle detector: edge loads, clears, runs, node counts.
module tb_top import dgcd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES  = 10000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;

  logic clk;
  logic rst_n;

  dgcd_in_if  in_ch ();
  dgcd_out_if out_ch ();
  dgcd_cfg_if cfg_ch ();

  directed_graph_cycle_detect dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the block: adjacency rows and node count
  row_t graph_rows [NODES];
  cnt_t node_limit = cnt_t'(NODES);
  bit   cyclic_expected [$];

  int   mismatches   = 0;
  int   runs_checked = 0;
  int   cyclic_seen  = 0;
  int   words_sent   = 0;
  int   cfg_writes   = 0;
  bit   jitter_on    = 1'b1;
  int   hold_req     = 0;
  int   hold_done    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 19);
    if (!jitter_on || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic node_t rnd_node();
    return node_t'($urandom_range(0, NODES - 1));
  endfunction

  // Depth-first walk with an explicit stack; stops at the first edge onto the path.
  function automatic bit graph_has_cycle();
    int n, root, depth, u, v;
    int stk_node [NODES];
    int stk_next [NODES];
    logic [NODES-1:0] seen, on_path;
    n = (node_limit > NODES) ? NODES : int'(node_limit);
    seen = '0;
    on_path = '0;
    for (root = 0; root < n; root++) begin
      if (seen[root]) continue;
      seen[root] = 1'b1;
      on_path[root] = 1'b1;
      stk_node[0] = root;
      stk_next[0] = 0;
      depth = 1;
      while (depth > 0) begin
        u = stk_node[depth-1];
        v = stk_next[depth-1];
        while (v < n && !graph_rows[u][v]) v++;
        if (v >= n) begin
          on_path[u] = 1'b0;
          depth--;
          continue;
        end
        stk_next[depth-1] = v + 1;
        if (on_path[v]) return 1'b1;
        if (!seen[v] && depth < NODES) begin
          seen[v] = 1'b1;
          on_path[v] = 1'b1;
          stk_node[depth] = v;
          stk_next[depth] = 0;
          depth++;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void apply_word(input logic [OP_W-1:0] op, input node_t s, input node_t d);
    case (op)
      OP_ADD: begin
        graph_rows[s][d] = 1'b1;
      end
      OP_CLEAR: begin
        foreach (graph_rows[i]) graph_rows[i] = '0;
      end
      OP_RUN: begin
        cyclic_expected.push_back(graph_has_cycle());
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input node_t s, input node_t d);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.src_node <= s;
    in_ch.dst_node <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    apply_word(op, s, d);
  endtask

  task automatic send_run();
    send_word(OP_RUN, rnd_node(), rnd_node());
  endtask

  task automatic send_clear();
    send_word(OP_CLEAR, rnd_node(), rnd_node());
  endtask

  // Sender goes quiet until every result is back, then lets trailing edge loads settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (cyclic_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input cnt_t v);
    wait_drained();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.node_count <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    node_limit = v;
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_run();                                   // empty graph
    send_word(OP_ADD, 5'd31, 5'd31);              // self loop on the top node
    send_run();
    send_clear();
    send_run();
    send_word(OP_ADD, 5'd0, 5'd1);
    send_word(OP_ADD, 5'd1, 5'd2);
    send_word(OP_ADD, 5'd2, 5'd0);
    send_word(OP_ADD, 5'd2, 5'd0);                // repeated edge
    send_run();
    send_clear();
    send_word(OP_ADD, 5'd0, 5'd31);
    send_word(OP_UNUSED, 5'd31, 5'd0);            // must be ignored
    send_run();
    send_word(OP_ADD, 5'd31, 5'd0);
    send_word(OP_UNUSED, 5'd0, 5'd31);
    send_run();
    send_clear();
    send_word(OP_ADD, 5'd5, 5'd3);
    send_word(OP_ADD, 5'd3, 5'd1);
    send_word(OP_ADD, 5'd1, 5'd0);
    send_word(OP_ADD, 5'd5, 5'd0);                // diamond, still acyclic
    send_run();
    send_word(OP_ADD, 5'd0, 5'd5);
    send_run();
  endtask

  // Zero, one, full and oversized node counts, with edges just inside and beyond the limit
  task automatic test_node_count_range();
    int counts [7] = '{1, 0, 63, 33, 2, 31, 32};
    int c, top;
    foreach (counts[i]) begin
      c = counts[i];
      top = (c > 1) ? c - 1 : 0;
      if (top > NODES - 1) top = NODES - 1;
      write_node_count(cnt_t'(c));
      send_clear();
      send_word(OP_ADD, node_t'(c), node_t'(c));
      send_run();
      send_word(OP_ADD, 5'd0, node_t'(top));
      send_run();
      send_word(OP_ADD, node_t'(top), 5'd0);
      send_run();
    end
  endtask

  // Receiver holds off while runs and edge loads keep coming; the second run must stall.
  task automatic test_backpressure();
    jitter_on = 1'b0;
    hold_req <= hold_req + 1;
    send_clear();
    send_word(OP_ADD, 5'd1, 5'd2);
    send_run();
    for (int i = 2; i < 8; i++) send_word(OP_ADD, node_t'(i), node_t'(i + 1));
    send_run();
    send_word(OP_ADD, 5'd8, 5'd1);
    send_run();
    send_word(OP_ADD, 5'd20, 5'd21);
    send_run();
    wait_drained();
    jitter_on = 1'b1;
  endtask

  function automatic cnt_t pick_count();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return cnt_t'(0);
    if (r == 1) return cnt_t'(1);
    if (r == 2) return cnt_t'($urandom_range(NODES + 1, 63));
    if (r < 6) return cnt_t'(NODES);
    return cnt_t'($urandom_range(2, 8));
  endfunction

  // Sets of optional clear, edges, run. Shapes: forward only, random, forward plus one back edge.
  task automatic test_random_graphs(input int budget);
    int stop_at, act, hi, k, shape, a, b;
    node_t s, d;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) write_node_count(pick_count());
      jitter_on = ($urandom_range(0, 4) != 0);
      act = (node_limit > NODES) ? NODES : int'(node_limit);
      hi = (act == 0) ? 0 : act - 1;
      if ($urandom_range(0, 2) != 0) send_clear();
      shape = $urandom_range(0, 2);
      k = $urandom_range(0, (act + 3 > 40) ? 40 : act + 3);
      for (int e = 0; e < k; e++) begin
        a = $urandom_range(0, hi);
        b = $urandom_range(0, hi);
        if ($urandom_range(0, 9) == 0) begin
          s = rnd_node();
          d = rnd_node();
        end else if (shape == 1) begin
          s = node_t'(a);
          d = node_t'(b);
        end else begin
          if (a == b) continue;
          s = node_t'((a < b) ? a : b);
          d = node_t'((a < b) ? b : a);
        end
        if ($urandom_range(0, 19) == 0) send_word(OP_UNUSED, rnd_node(), rnd_node());
        send_word(OP_ADD, s, d);
      end
      if (shape == 2 && hi > 0) begin
        a = $urandom_range(1, hi);
        b = $urandom_range(0, a);
        send_word(OP_ADD, node_t'(a), node_t'(b));
      end
      send_run();
    end
  endtask

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && jitter_on && $urandom_range(0, 3) == 0) begin
        stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    bit want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cyclic_expected.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual cyclic=%0b",
                 $time, out_ch.cyclic);
        mismatches++;
      end else begin
        want = cyclic_expected.pop_front();
        runs_checked++;
        if (want) cyclic_seen++;
        if (out_ch.cyclic !== want) begin
          $display("%0t: cyclic mismatch, expected %0b, actual %0b", $time, want, out_ch.cyclic);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL directed_graph_cycle_detect");
    $finish;
  end

  initial begin
    foreach (graph_rows[i]) graph_rows[i] = '0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_ADD;
    in_ch.src_node    <= '0;
    in_ch.dst_node    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.node_count <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_node_count_range();
    test_backpressure();
    test_random_graphs(380);
    wait_drained();

    $display("Sent %0d words, checked %0d runs (%0d cyclic, %0d acyclic).",
             words_sent, runs_checked, cyclic_seen, runs_checked - cyclic_seen);
    $display("Node count written %0d times: 0, 1, 32, past 32 and small sizes; long output hold.",
             cfg_writes);
    if (mismatches == 0 && cyclic_expected.size() == 0) begin
      $display("PASS directed_graph_cycle_detect");
    end else begin
      $display("FAIL directed_graph_cycle_detect");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dgcd_pkg.sv
sv/dgcd_if.sv
sv/directed_graph_cycle_detect.sv
bench/tb_top.sv
